// ----- rtl/tekd_pkg.sv -----
// ----------------------------------------------------------------------------
// tekd_pkg
// Shared types and constants of the terminal escape key decoder: beat
// payload structs, event codes, register indexes and the VT100 key table.
// ----------------------------------------------------------------------------
package tekd_pkg;

    // Sequence buffer depth default and key table dimensions.
    localparam int MAX_SEQ_LEN_DEF = 5;
    localparam int KEY_COUNT       = 22;
    localparam int KEY_BYTES       = 5;
    localparam int ARROW_KEYS      = 4;
    localparam int KEY_CODE_W      = 5;

    // Byte that opens every escape sequence.
    localparam logic [7:0] ESC_BYTE = 8'd27;

    // Key codes that carry a shell action.
    localparam logic [KEY_CODE_W-1:0] KEY_LEFT = 5'd0;
    localparam logic [KEY_CODE_W-1:0] KEY_UP   = 5'd2;
    localparam logic [KEY_CODE_W-1:0] KEY_DOWN = 5'd3;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_NEWLINE  = 3'd1,
        EV_RETURN   = 3'd2,
        EV_BACKSP   = 3'd3,
        EV_ESC      = 3'd4,
        EV_PENDING  = 3'd5,
        EV_KEY      = 3'd6,
        EV_DROP     = 3'd7
    } event_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARROW_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGIN_EN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETURN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE = 3'd5;

    // Register reset values.
    localparam logic [7:0] TIMEOUT_RST   = 8'd5;
    localparam logic       ARROW_EN_RST  = 1'b1;
    localparam logic       LOGIN_EN_RST  = 1'b0;
    localparam logic [7:0] NEWLINE_RST   = 8'd10;
    localparam logic [7:0] RETURN_RST    = 8'd13;
    localparam logic [7:0] BACKSP_RST    = 8'd8;

    // Input beat payload.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [7:0] gap_ms;
        logic       logged_in;
    } rx_item_t;

    // Result beat payload.
    typedef struct packed {
        logic                  consumed;
        logic [2:0]            event_res;
        logic [KEY_CODE_W-1:0] key_code;
        logic                  run_action;
    } ev_item_t;

    // One key table entry: sequence length and its bytes, first byte at 0.
    typedef struct packed {
        logic [2:0]                  len;
        logic [0:KEY_BYTES-1][7:0]   b;
    } key_entry_t;

    localparam key_entry_t KEY_TABLE [KEY_COUNT] = '{
        '{len: 3'd3, b: '{8'd27, 8'd91, 8'd68,  8'd0,   8'd0}},
        '{len: 3'd3, b: '{8'd27, 8'd91, 8'd67,  8'd0,   8'd0}},
        '{len: 3'd3, b: '{8'd27, 8'd91, 8'd65,  8'd0,   8'd0}},
        '{len: 3'd3, b: '{8'd27, 8'd91, 8'd66,  8'd0,   8'd0}},
        '{len: 3'd3, b: '{8'd27, 8'd79, 8'd80,  8'd0,   8'd0}},
        '{len: 3'd3, b: '{8'd27, 8'd79, 8'd81,  8'd0,   8'd0}},
        '{len: 3'd3, b: '{8'd27, 8'd79, 8'd82,  8'd0,   8'd0}},
        '{len: 3'd3, b: '{8'd27, 8'd79, 8'd83,  8'd0,   8'd0}},
        '{len: 3'd5, b: '{8'd27, 8'd91, 8'd49,  8'd53,  8'd126}},
        '{len: 3'd5, b: '{8'd27, 8'd91, 8'd49,  8'd55,  8'd126}},
        '{len: 3'd5, b: '{8'd27, 8'd91, 8'd49,  8'd56,  8'd126}},
        '{len: 3'd5, b: '{8'd27, 8'd91, 8'd49,  8'd57,  8'd126}},
        '{len: 3'd5, b: '{8'd27, 8'd91, 8'd50,  8'd48,  8'd126}},
        '{len: 3'd5, b: '{8'd27, 8'd91, 8'd50,  8'd49,  8'd126}},
        '{len: 3'd5, b: '{8'd27, 8'd91, 8'd50,  8'd51,  8'd126}},
        '{len: 3'd5, b: '{8'd27, 8'd91, 8'd50,  8'd52,  8'd126}},
        '{len: 3'd4, b: '{8'd27, 8'd91, 8'd50,  8'd126, 8'd0}},
        '{len: 3'd4, b: '{8'd27, 8'd91, 8'd51,  8'd126, 8'd0}},
        '{len: 3'd4, b: '{8'd27, 8'd91, 8'd53,  8'd126, 8'd0}},
        '{len: 3'd4, b: '{8'd27, 8'd91, 8'd54,  8'd126, 8'd0}},
        '{len: 3'd3, b: '{8'd27, 8'd91, 8'd72,  8'd0,   8'd0}},
        '{len: 3'd3, b: '{8'd27, 8'd91, 8'd70,  8'd0,   8'd0}}
    };

endpackage

// ----- rtl/terminal_escape_key_decoder.sv -----
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder
// Classifies received terminal bytes and decodes VT100 escape key sequences.
// ----------------------------------------------------------------------------
// Usage:
// Each rx beat carries one received byte, the gap in milliseconds since the
// previous byte and the login status. Each rx beat produces exactly one ev
// beat telling whether the byte was consumed, which event it caused and, for
// a recognized key, its key code and whether the shell action should run.
// The cfg channel writes the six registers by index; it is always ready and
// is meant to be used only while no rx beat is in flight.
// A byte is captured in an input register, decoded by one short compare
// stage against the key table and captured in the result register. One
// byte per cycle is sustained while the ev receiver stays ready; the escape
// sequence buffer is updated as each byte leaves the input register, so
// consecutive bytes see each other's effect without bubbles.
// When the ev receiver stalls, the result register holds its beat, the
// input register holds the next byte and rx_ready drops once both are full.
// Reset empties both registers, clears the pending sequence and loads the
// register defaults (timeout 5, arrows on, login check off, LF, CR, BS).
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder #(
    parameter int MAX_SEQ_LEN = tekd_pkg::MAX_SEQ_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              rx_valid,
    output logic                              rx_ready,
    input  tekd_pkg::rx_item_t                rx_item,
    output logic                              ev_valid,
    input  logic                              ev_ready,
    output tekd_pkg::ev_item_t                ev_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tekd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tekd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tekd_pkg::*;

    localparam int LEN_W     = $clog2(MAX_SEQ_LEN + 1);
    localparam int STORE_LEN = (MAX_SEQ_LEN < KEY_BYTES) ? MAX_SEQ_LEN : KEY_BYTES;

    // Configuration registers.
    logic [7:0] timeout_reg;
    logic       arrow_en_reg;
    logic       login_en_reg;
    logic [7:0] newline_reg;
    logic [7:0] return_reg;
    logic [7:0] backsp_reg;

    // Pipeline registers.
    logic       s1_valid_reg;
    rx_item_t   s1_item_reg;
    logic       ev_valid_reg;
    ev_item_t   ev_item_reg;

    // Sequence buffer.
    logic [LEN_W-1:0] seq_len_reg;
    logic [LEN_W-1:0] seq_len_next;
    logic [7:0]       seq_bytes_reg [STORE_LEN];

    // Decode signals.
    logic                  s1_go;
    logic                  esc_start;
    logic                  append;
    logic [LEN_W-1:0]      new_len;
    logic [7:0]            new_seq [KEY_BYTES];
    logic [KEY_COUNT-1:0]  key_hit;
    logic [KEY_CODE_W-1:0] key_idx;
    ev_item_t              ev_item_next;

    // The input stage moves on when the result register is free or draining.
    assign s1_go     = s1_valid_reg && (!ev_valid_reg || ev_ready);
    assign rx_ready  = !s1_valid_reg || s1_go;
    assign cfg_ready = 1'b1;
    assign ev_valid  = ev_valid_reg;
    assign ev_item   = ev_item_reg;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RST;
            arrow_en_reg <= ARROW_EN_RST;
            login_en_reg <= LOGIN_EN_RST;
            newline_reg  <= NEWLINE_RST;
            return_reg   <= RETURN_RST;
            backsp_reg   <= BACKSP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT:   timeout_reg  <= cfg_data;
                CFG_ARROW_EN:  arrow_en_reg <= cfg_data[0];
                CFG_LOGIN_EN:  login_en_reg <= cfg_data[0];
                CFG_NEWLINE:   newline_reg  <= cfg_data;
                CFG_RETURN:    return_reg   <= cfg_data;
                CFG_BACKSPACE: backsp_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // The sequence as it would look with the current byte appended.
    assign new_len = seq_len_reg + LEN_W'(1);

    for (genvar j = 0; j < KEY_BYTES; j++)
    begin : g_new_seq
        if (j < STORE_LEN)
        begin : g_stored
            assign new_seq[j] = (seq_len_reg == LEN_W'(j)) ? s1_item_reg.rx_byte
                                                           : seq_bytes_reg[j];
        end
        else
        begin : g_absent
            assign new_seq[j] = 8'd0;
        end
    end

    // Parallel compare against every key table entry of the same length.
    always_comb
    begin
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            key_hit[k] = (4'(KEY_TABLE[k].len) == 4'(new_len))
                         && (arrow_en_reg || (k >= ARROW_KEYS));
            for (int j = 0; j < KEY_BYTES; j++)
            begin
                if ((j < int'(KEY_TABLE[k].len)) && (new_seq[j] != KEY_TABLE[k].b[j]))
                begin
                    key_hit[k] = 1'b0;
                end
            end
        end
    end

    // Encode the hit; the lowest index wins.
    always_comb
    begin
        key_idx = '0;
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            if (key_hit[k])
            begin
                key_idx = KEY_CODE_W'(k);
            end
        end
    end

    // Byte classification and sequence bookkeeping.
    always_comb
    begin
        ev_item_next = '0;
        ev_item_next.event_res = EV_NONE;
        seq_len_next = seq_len_reg;
        esc_start    = 1'b0;
        append       = 1'b0;
        if ((seq_len_reg == '0) || (s1_item_reg.gap_ms > timeout_reg))
        begin
            // Fresh byte: control characters first, then escape.
            if (s1_item_reg.rx_byte == newline_reg)
            begin
                ev_item_next.consumed  = 1'b1;
                ev_item_next.event_res = EV_NEWLINE;
            end
            else if (s1_item_reg.rx_byte == return_reg)
            begin
                ev_item_next.consumed  = 1'b1;
                ev_item_next.event_res = EV_RETURN;
            end
            else if (s1_item_reg.rx_byte == backsp_reg)
            begin
                ev_item_next.consumed  = 1'b1;
                ev_item_next.event_res = EV_BACKSP;
            end
            else if (s1_item_reg.rx_byte == ESC_BYTE)
            begin
                ev_item_next.consumed  = 1'b1;
                ev_item_next.event_res = EV_ESC;
                seq_len_next = LEN_W'(1);
                esc_start    = 1'b1;
            end
        end
        else if (s1_item_reg.gap_ms < timeout_reg)
        begin
            // Continuation of a pending sequence.
            ev_item_next.consumed = 1'b1;
            append = 1'b1;
            if (|key_hit)
            begin
                ev_item_next.event_res  = EV_KEY;
                ev_item_next.key_code   = key_idx;
                ev_item_next.run_action = ((key_idx == KEY_LEFT) || (key_idx == KEY_UP)
                                           || (key_idx == KEY_DOWN))
                                          && (!login_en_reg || s1_item_reg.logged_in);
                seq_len_next = '0;
            end
            else if (new_len == LEN_W'(MAX_SEQ_LEN))
            begin
                ev_item_next.event_res = EV_DROP;
                seq_len_next = '0;
            end
            else
            begin
                ev_item_next.event_res = EV_PENDING;
                seq_len_next = new_len;
            end
        end
    end

    // Control registers of both stages and the sequence length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ev_valid_reg <= 1'b0;
            seq_len_reg  <= '0;
        end
        else
        begin
            if (rx_ready)
            begin
                s1_valid_reg <= rx_valid;
            end
            if (s1_go)
            begin
                ev_valid_reg <= 1'b1;
                seq_len_reg  <= seq_len_next;
            end
            else if (ev_ready)
            begin
                ev_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            s1_item_reg <= rx_item;
        end
        if (s1_go)
        begin
            ev_item_reg <= ev_item_next;
        end
    end

    // Sequence bytes: escape lands at the head, continuation bytes append.
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < STORE_LEN; j++)
        begin
            if (s1_go && esc_start && (j == 0))
            begin
                seq_bytes_reg[j] <= s1_item_reg.rx_byte;
            end
            else if (s1_go && append && (seq_len_reg == LEN_W'(j)))
            begin
                seq_bytes_reg[j] <= s1_item_reg.rx_byte;
            end
        end
    end

    // A pending sequence never reaches the full buffer length.
    a_len_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        seq_len_reg < LEN_W'(MAX_SEQ_LEN))
        else $error("sequence length reached the buffer depth");

    // A recognized key or a dropped sequence leaves nothing pending.
    a_cleared_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && ((ev_item_next.event_res == EV_KEY) || (ev_item_next.event_res == EV_DROP))
        |=> seq_len_reg == '0)
        else $error("sequence not cleared after key or drop");

    // An action only comes with a recognized left, up or down key.
    a_action_key: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg && ev_item_reg.run_action
        |-> (ev_item_reg.event_res == EV_KEY)
            && ((ev_item_reg.key_code == KEY_LEFT) || (ev_item_reg.key_code == KEY_UP)
                || (ev_item_reg.key_code == KEY_DOWN)))
        else $error("action raised without an action key");

    // A byte is taken into a full input stage only while that stage drains.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        rx_valid && rx_ready && s1_valid_reg |-> s1_go)
        else $error("input stage overwritten");

endmodule

// ----- tb/tb_terminal_escape_key_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_terminal_escape_key_decoder
// Self-checking bench for the VT100 escape key decoder. A short scripted
// sequence covers control characters, the timeout edge, stale sequences,
// dropped sequences, the login check, disabled arrows and a zero timeout.
// Six random phases then feed mostly well-formed key sequences under
// several register settings. Every ev beat is compared with its scripted
// result or with a behavioral decoder that runs on each accepted rx beat.
// ----------------------------------------------------------------------------
module tb_terminal_escape_key_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import tekd_pkg::*;

    localparam int SEQ_DEPTH      = 5;
    localparam int ITEMS_PER_PASS = 320;
    localparam int PASS_COUNT     = 6;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int SHOWN_ERRORS   = 10;

    // One scripted step: either an rx beat or a register write.
    typedef struct packed {
        logic                  is_write;
        rx_item_t              item;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  checked;
        ev_item_t              want;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  rx_valid = 1'b0;
    logic                  rx_ready;
    rx_item_t              rx_item = '0;
    logic                  ev_valid;
    logic                  ev_ready = 1'b0;
    ev_item_t              ev_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Decoder copy of the registers and the escape sequence buffer.
    logic [7:0] cfg_timeout   = 8'd5;
    logic       cfg_arrow_en  = 1'b1;
    logic       cfg_login_en  = 1'b0;
    logic [7:0] cfg_newline   = 8'd10;
    logic [7:0] cfg_return    = 8'd13;
    logic [7:0] cfg_backspace = 8'd8;
    logic [7:0] seq_buf [0:SEQ_DEPTH-1];
    int         seq_len = 0;

    ev_item_t    expected_events [$];
    script_row_t script [$];
    rx_item_t    burst [$];

    int   mismatches = 0;
    int   stall_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_left = 0;
    logic hold_req = 1'b0;
    logic hold_seen = 1'b0;

    always #2 clk = ~clk;

    terminal_escape_key_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_item   (rx_item),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .ev_item   (ev_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // VT100 key table: length in the top three bits, then bytes from ESC on.
    function automatic logic [42:0] key_pattern(input int k);
        case (k)
            // Arrows: left, right, up, down.
            0:  return {3'd3, 8'd27, 8'd91, 8'd68, 16'd0};
            1:  return {3'd3, 8'd27, 8'd91, 8'd67, 16'd0};
            2:  return {3'd3, 8'd27, 8'd91, 8'd65, 16'd0};
            3:  return {3'd3, 8'd27, 8'd91, 8'd66, 16'd0};
            // F1 to F4 in their short form.
            4:  return {3'd3, 8'd27, 8'd79, 8'd80, 16'd0};
            5:  return {3'd3, 8'd27, 8'd79, 8'd81, 16'd0};
            6:  return {3'd3, 8'd27, 8'd79, 8'd82, 16'd0};
            7:  return {3'd3, 8'd27, 8'd79, 8'd83, 16'd0};
            // F5 to F12.
            8:  return {3'd5, 8'd27, 8'd91, 8'd49, 8'd53, 8'd126};
            9:  return {3'd5, 8'd27, 8'd91, 8'd49, 8'd55, 8'd126};
            10: return {3'd5, 8'd27, 8'd91, 8'd49, 8'd56, 8'd126};
            11: return {3'd5, 8'd27, 8'd91, 8'd49, 8'd57, 8'd126};
            12: return {3'd5, 8'd27, 8'd91, 8'd50, 8'd48, 8'd126};
            13: return {3'd5, 8'd27, 8'd91, 8'd50, 8'd49, 8'd126};
            14: return {3'd5, 8'd27, 8'd91, 8'd50, 8'd51, 8'd126};
            15: return {3'd5, 8'd27, 8'd91, 8'd50, 8'd52, 8'd126};
            // Insert, delete, page up, page down.
            16: return {3'd4, 8'd27, 8'd91, 8'd50, 8'd126, 8'd0};
            17: return {3'd4, 8'd27, 8'd91, 8'd51, 8'd126, 8'd0};
            18: return {3'd4, 8'd27, 8'd91, 8'd53, 8'd126, 8'd0};
            19: return {3'd4, 8'd27, 8'd91, 8'd54, 8'd126, 8'd0};
            // Home and end.
            20: return {3'd3, 8'd27, 8'd91, 8'd72, 16'd0};
            21: return {3'd3, 8'd27, 8'd91, 8'd70, 16'd0};
            default: return '0;
        endcase
    endfunction

    // Index of the key whose sequence equals the buffer, or -1.
    function automatic int find_key();
        logic [42:0] pat;
        logic        same;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            pat = key_pattern(k);
            if (k < ARROW_KEYS && !cfg_arrow_en)
                continue;
            if (int'(pat[42:40]) != seq_len)
                continue;
            same = 1'b1;
            for (int j = 0; j < seq_len; j++)
            begin
                if (seq_buf[j] != pat[39-8*j -: 8])
                    same = 1'b0;
            end
            if (same)
                return k;
        end
        return -1;
    endfunction

    // Decodes one received byte and advances the sequence buffer.
    function automatic ev_item_t decode_byte(input rx_item_t it);
        ev_item_t r;
        int       k;
        r = '0;
        if (seq_len == 0 || it.gap_ms > cfg_timeout)
        begin
            // Fresh byte: control characters in priority order, then ESC.
            if (it.rx_byte == cfg_newline)
            begin
                r.consumed  = 1'b1;
                r.event_res = EV_NEWLINE;
            end
            else if (it.rx_byte == cfg_return)
            begin
                r.consumed  = 1'b1;
                r.event_res = EV_RETURN;
            end
            else if (it.rx_byte == cfg_backspace)
            begin
                r.consumed  = 1'b1;
                r.event_res = EV_BACKSP;
            end
            else if (it.rx_byte == ESC_BYTE)
            begin
                seq_buf[0]  = ESC_BYTE;
                seq_len     = 1;
                r.consumed  = 1'b1;
                r.event_res = EV_ESC;
            end
        end
        else if (it.gap_ms < cfg_timeout)
        begin
            // Continuation of a pending sequence.
            r.consumed = 1'b1;
            if (seq_len < SEQ_DEPTH)
            begin
                seq_buf[seq_len] = it.rx_byte;
                seq_len++;
            end
            k = find_key();
            if (k >= 0)
            begin
                seq_len     = 0;
                r.event_res = EV_KEY;
                r.key_code  = k[KEY_CODE_W-1:0];
                if ((r.key_code == KEY_LEFT || r.key_code == KEY_UP ||
                     r.key_code == KEY_DOWN) && (!cfg_login_en || it.logged_in))
                    r.run_action = 1'b1;
            end
            else if (seq_len >= SEQ_DEPTH)
            begin
                seq_len     = 0;
                r.event_res = EV_DROP;
            end
            else
                r.event_res = EV_PENDING;
        end
        // A gap equal to the timeout leaves a byte of a pending sequence unconsumed.
        return r;
    endfunction

    function automatic ev_item_t mk_ev(input logic c, input event_t e,
                                       input logic [KEY_CODE_W-1:0] k, input logic a);
        ev_item_t r;
        r.consumed   = c;
        r.event_res  = e;
        r.key_code   = k;
        r.run_action = a;
        return r;
    endfunction

    function automatic rx_item_t mk_rx(input logic [7:0] b, input logic [7:0] g);
        rx_item_t r;
        r.rx_byte   = b;
        r.gap_ms    = g;
        r.logged_in = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Script entries for the directed part.
    function automatic void add_checked(input logic [7:0] b, input logic [7:0] g,
                                        input logic l, input ev_item_t want);
        script_row_t row;
        row = '0;
        row.item.rx_byte   = b;
        row.item.gap_ms    = g;
        row.item.logged_in = l;
        row.checked        = 1'b1;
        row.want           = want;
        script.push_back(row);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic [7:0] g,
                                     input logic l);
        add_checked(b, g, l, '0);
        script[script.size()-1].checked = 1'b0;
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        script_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        script.push_back(row);
    endfunction

    // Gap for a byte inside a sequence: mostly in time, sometimes late or
    // exactly on the timeout.
    function automatic logic [7:0] cont_gap();
        logic [7:0] g;
        int         p;
        p = $urandom_range(0, 19);
        if (p == 1)
            g = 8'($urandom_range(cfg_timeout, 255));
        else if (cfg_timeout == 0 || p == 0)
            g = cfg_timeout;
        else
            g = 8'($urandom_range(0, cfg_timeout - 1));
        return g;
    endfunction

    // Builds the next group of random rx beats.
    task automatic gen_burst();
        logic [42:0] pat;
        logic [7:0]  b;
        int          p;
        int          n;
        p = $urandom_range(0, 99);
        if (p < 55)
        begin
            // A table key, with an occasional corrupted byte.
            pat = key_pattern($urandom_range(0, KEY_COUNT - 1));
            burst.push_back(mk_rx(ESC_BYTE, 8'($urandom_range(0, 255))));
            for (int j = 1; j < int'(pat[42:40]); j++)
            begin
                b = pat[39-8*j -: 8];
                if ($urandom_range(0, 29) == 0)
                    b = 8'($urandom_range(0, 255));
                burst.push_back(mk_rx(b, cont_gap()));
            end
        end
        else if (p < 70)
        begin
            // ESC followed by bytes that look like a sequence but rarely are.
            burst.push_back(mk_rx(ESC_BYTE, 8'($urandom_range(0, 255))));
            n = $urandom_range(1, SEQ_DEPTH);
            for (int j = 0; j < n; j++)
            begin
                case ($urandom_range(0, 3))
                    0: b = 8'($urandom_range(0, 255));
                    1: b = 8'd91;
                    2: b = 8'($urandom_range(48, 57));
                    default: b = 8'd126;
                endcase
                burst.push_back(mk_rx(b, cont_gap()));
            end
        end
        else if (p < 82)
        begin
            case ($urandom_range(0, 3))
                0: b = cfg_newline;
                1: b = cfg_return;
                2: b = cfg_backspace;
                default: b = ESC_BYTE;
            endcase
            burst.push_back(mk_rx(b, 8'($urandom_range(0, 255))));
        end
        else
        begin
            n = $urandom_range(1, 3);
            for (int j = 0; j < n; j++)
                burst.push_back(mk_rx(8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255))));
        end
    endtask

    // Offers one rx beat and records its expected result once accepted.
    task automatic send_item(input rx_item_t it, input logic checked,
                             input ev_item_t want);
        ev_item_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_item  <= it;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        pred = decode_byte(it);
        expected_events.push_back(checked ? want : pred);
    endtask

    // Lets every outstanding result arrive before the block is touched.
    task automatic drain_results();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_TIMEOUT:   cfg_timeout   = val;
            CFG_ARROW_EN:  cfg_arrow_en  = val[0];
            CFG_LOGIN_EN:  cfg_login_en  = val[0];
            CFG_NEWLINE:   cfg_newline   = val;
            CFG_RETURN:    cfg_return    = val;
            CFG_BACKSPACE: cfg_backspace = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Register settings of one random pass.
    task automatic setup_pass(input int pass);
        int t;
        int a;
        int l;
        int nl;
        int cr;
        int bs;
        case (pass)
            0: begin t = 5;   a = 1; l = 0; nl = 10;  cr = 13;  bs = 8;   end
            1: begin t = 255; a = 0; l = 1; nl = 0;   cr = 255; bs = 127; end
            2: begin t = 0;   a = 1; l = 0; nl = 10;  cr = 10;  bs = 13;  end
            3: begin t = 1;   a = 1; l = 1; nl = 126; cr = 91;  bs = 79;  end
            4: begin t = 128; a = 1; l = 0; nl = 10;  cr = 13;  bs = 127; end
            default:
            begin
                t  = $urandom_range(1, 40);
                a  = $urandom_range(0, 1);
                l  = $urandom_range(0, 1);
                nl = $urandom_range(0, 255);
                cr = $urandom_range(0, 255);
                bs = $urandom_range(0, 255);
            end
        endcase
        write_reg(CFG_TIMEOUT, CFG_DATA_W'(t));
        write_reg(CFG_ARROW_EN, CFG_DATA_W'(a));
        write_reg(CFG_LOGIN_EN, CFG_DATA_W'(l));
        write_reg(CFG_NEWLINE, CFG_DATA_W'(nl));
        write_reg(CFG_RETURN, CFG_DATA_W'(cr));
        write_reg(CFG_BACKSPACE, CFG_DATA_W'(bs));
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            ev_ready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            ev_ready  <= 1'b0;
        end
        else
            ev_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare each ev beat with the oldest expected result.
    always @(posedge clk)
    begin
        ev_item_t want;
        if (rst_n && ev_valid && ev_ready)
        begin
            if (expected_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected ev beat: c=%0d ev=%0d key=%0d act=%0d",
                             ev_item.consumed, ev_item.event_res,
                             ev_item.key_code, ev_item.run_action);
            end
            else
            begin
                want = expected_events.pop_front();
                if (ev_item.consumed !== want.consumed ||
                    ev_item.event_res !== want.event_res ||
                    ev_item.key_code !== want.key_code ||
                    ev_item.run_action !== want.run_action)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                    begin
                        $display("ev mismatch at %0t: expected c=%0d ev=%0d key=%0d act=%0d",
                                 $realtime, want.consumed, want.event_res,
                                 want.key_code, want.run_action);
                        $display("    got c=%0d ev=%0d key=%0d act=%0d",
                                 ev_item.consumed, ev_item.event_res,
                                 ev_item.key_code, ev_item.run_action);
                    end
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (rx_valid && rx_ready) || (ev_valid && ev_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        script_row_t row;
        int          sent;

        // Control characters at reset values, and bytes that mean nothing.
        add_checked(8'd10, 8'd0, 1'b0, mk_ev(1'b1, EV_NEWLINE, 5'd0, 1'b0));
        add_checked(8'd13, 8'd255, 1'b1, mk_ev(1'b1, EV_RETURN, 5'd0, 1'b0));
        add_checked(8'd8, 8'd128, 1'b0, mk_ev(1'b1, EV_BACKSP, 5'd0, 1'b0));
        add_checked(8'd0, 8'd0, 1'b0, mk_ev(1'b0, EV_NONE, 5'd0, 1'b0));
        add_checked(8'd255, 8'd255, 1'b1, mk_ev(1'b0, EV_NONE, 5'd0, 1'b0));
        // Left arrow, one byte held back by a gap equal to the timeout.
        add_checked(8'd27, 8'd0, 1'b0, mk_ev(1'b1, EV_ESC, 5'd0, 1'b0));
        add_checked(8'd91, 8'd5, 1'b0, mk_ev(1'b0, EV_NONE, 5'd0, 1'b0));
        add_checked(8'd91, 8'd4, 1'b0, mk_ev(1'b1, EV_PENDING, 5'd0, 1'b0));
        add_checked(8'd68, 8'd0, 1'b1, mk_ev(1'b1, EV_KEY, KEY_LEFT, 1'b1));
        // A late ordinary byte leaves the sequence pending; F4 then completes.
        add_checked(8'd27, 8'd3, 1'b0, mk_ev(1'b1, EV_ESC, 5'd0, 1'b0));
        add_checked(8'd79, 8'd9, 1'b0, mk_ev(1'b0, EV_NONE, 5'd0, 1'b0));
        add_byte(8'd79, 8'd1, 1'b0);
        add_byte(8'd83, 8'd0, 1'b0);
        // A full-length unknown sequence is dropped.
        add_byte(8'd27, 8'd0, 1'b0);
        add_byte(8'd91, 8'd0, 1'b0);
        add_byte(8'd57, 8'd1, 1'b0);
        add_byte(8'd57, 8'd2, 1'b0);
        add_checked(8'd57, 8'd3, 1'b0, mk_ev(1'b1, EV_DROP, 5'd0, 1'b0));
        // Login check keeps the up arrow code but suppresses its action.
        add_write(CFG_LOGIN_EN, 8'd1);
        add_byte(8'd27, 8'd0, 1'b0);
        add_byte(8'd91, 8'd0, 1'b0);
        add_checked(8'd65, 8'd0, 1'b0, mk_ev(1'b1, EV_KEY, KEY_UP, 1'b0));
        // With arrows disabled the left arrow stays pending.
        add_write(CFG_ARROW_EN, 8'd0);
        add_byte(8'd27, 8'd0, 1'b1);
        add_byte(8'd91, 8'd0, 1'b1);
        add_checked(8'd68, 8'd0, 1'b1, mk_ev(1'b1, EV_PENDING, 5'd0, 1'b0));
        // Zero timeout; newline set to the ESC value takes priority.
        add_write(CFG_TIMEOUT, 8'd0);
        add_write(CFG_NEWLINE, 8'd27);
        add_checked(8'd27, 8'd1, 1'b0, mk_ev(1'b1, EV_NEWLINE, 5'd0, 1'b0));
        add_write(CFG_NEWLINE, 8'd10);
        add_checked(8'd27, 8'd7, 1'b0, mk_ev(1'b1, EV_ESC, 5'd0, 1'b0));
        add_checked(8'd91, 8'd0, 1'b0, mk_ev(1'b0, EV_NONE, 5'd0, 1'b0));

        // Hold reset, then release it.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script.
        send_idle_pct = 18;
        recv_stall_pct <= 77;
        foreach (script[i])
        begin
            row = script[i];
            if (row.is_write)
            begin
                drain_results();
                write_reg(row.reg_idx, row.reg_val);
            end
            else
                send_item(row.item, row.checked, row.want);
        end

        // Random passes under different settings and flow-control mixes.
        for (int pass = 0; pass < PASS_COUNT; pass++)
        begin
            drain_results();
            setup_pass(pass);
            if (pass < 2)
            begin
                send_idle_pct = 18;
                recv_stall_pct <= 77;
            end
            else if (pass < 4)
            begin
                send_idle_pct = 77;
                recv_stall_pct <= 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct <= 0;
            end
            // Long receiver hold-off while the sender keeps offering beats.
            if (pass == 4)
                hold_req <= ~hold_req;
            sent = 0;
            while (sent < ITEMS_PER_PASS)
            begin
                gen_burst();
                while (burst.size() != 0)
                begin
                    send_item(burst.pop_front(), 1'b0, '0);
                    sent++;
                end
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- terminal_escape_key_decoder.f -----
rtl/tekd_pkg.sv
rtl/terminal_escape_key_decoder.sv
tb/tb_terminal_escape_key_decoder.sv
